>>> src/snt_pkg.sv
// Shared types and constants for the second/nanosecond time arithmetic unit.
// No dependencies; every other file in src imports this package.
`default_nettype none

package snt_pkg;

  // Pipeline depth: register stages from the input transfer to the output register
  localparam int NSTAGE = 5;

  // Default width of the internal seconds arithmetic
  localparam int SEC_WIDTH_DEF = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_ADD       = 3'd0,
    OP_SUB       = 3'd1,
    OP_NORM      = 3'd2,
    OP_FROM_MS   = 3'd3,
    OP_FROM_US   = 3'd4,
    OP_TO_NS     = 3'd5
  } op_t;

  // Clamp status codes
  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } st_t;

  // Nanosecond constants in the 34-bit signed fix-up domain
  localparam logic signed [33:0] NS1_34 = 34'sd1000000000;
  localparam logic signed [33:0] NS2_34 = 34'sd2000000000;
  localparam logic signed [33:0] NS3_34 = 34'sd3000000000;

  // Nanoseconds per second for the to-nanoseconds multiply
  localparam logic signed [31:0] NS_PER_SEC_32 = 32'sd1000000000;

  // Nanoseconds field of the infinity value
  localparam logic signed [31:0] NS_MAX = 32'sd999999999;

  // Count conversion: quotient estimate is (count * RECIP) >> SHIFT, short by at most one
  localparam int                PROD_W   = 63;
  localparam int                QUO_W    = 22;
  localparam int                REM_W    = 20;
  localparam int                DIV_W    = 20;
  localparam logic [31:0]       RECIP_MS = 32'd2199023255;  // floor(2^41 / 1000)
  localparam logic [31:0]       RECIP_US = 32'd2251799813;  // floor(2^51 / 1000000)
  localparam int                SHIFT_MS = 41;
  localparam int                SHIFT_US = 51;
  localparam logic [DIV_W-1:0]  DIV_MS   = 20'd1000;
  localparam logic [DIV_W-1:0]  DIV_US   = 20'd1000000;
  localparam logic [DIV_W-1:0]  SCALE_MS = 20'd1000000;
  localparam logic [DIV_W-1:0]  SCALE_US = 20'd1000;

  // Input item
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_sec;
    logic signed [31:0] a_nsec;
    logic signed [31:0] b_sec;
    logic signed [31:0] b_nsec;
    logic [30:0]        count_in;
  } in_t;

  // Result item
  typedef struct packed {
    logic signed [31:0] res_sec;
    logic signed [31:0] res_nsec;
    logic signed [63:0] total_ns;
    logic [1:0]         clamp_status;
  } out_t;

  // Per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NSTAGE-1:0] load;
  } pipe_ctl_t;

endpackage

`default_nettype wire

>>> src/snt_pipe_ctrl.sv
// Valid bits and per-stage load enables for the five-stage datapath.
// Depends on snt_pkg.
`default_nettype none

module snt_pipe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output snt_pkg::pipe_ctl_t     ctl
);
  import snt_pkg::*;

  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] rdy;
  logic [NSTAGE-1:0] vld_up;

  // A stage loads when it is empty or the stage after it moves on
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || !out_stall;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  // Valid bits follow the data
  assign vld_up = {vld_r[NSTAGE-2:0], in_valid};

  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < NSTAGE; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = vld_up[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTAGE-1];
  assign ctl.load  = rdy;

endmodule

`default_nettype wire

>>> src/snt_time_path.sv
// Add, subtract and normalize datapath: sums, one fix-up step, clamp/saturate.
// Depends on snt_pkg; load enables come from snt_pipe_ctrl.
`default_nettype none

module snt_time_path #(
  parameter int SEC_WIDTH = snt_pkg::SEC_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire snt_pkg::pipe_ctl_t  ctl,
  input  wire snt_pkg::in_t        in_data,
  output snt_pkg::out_t            res
);
  import snt_pkg::*;

  localparam logic [SEC_WIDTH-1:0] SEC_MAX = {1'b0, {(SEC_WIDTH-1){1'b1}}};
  localparam logic [SEC_WIDTH-1:0] SEC_ONE = SEC_WIDTH'(1);
  localparam logic [SEC_WIDTH-1:0] SEC_TWO = SEC_WIDTH'(2);
  localparam logic [SEC_WIDTH-1:0] SEC_THR = SEC_WIDTH'(3);

  // ---------------- stage 1: raw sums ----------------
  logic signed [31:0]    a_s, b_s, an_s, bn_s;
  logic [SEC_WIDTH-1:0]  as_ext, bs_ext;
  logic signed [33:0]    an_in, bn_in;
  logic [SEC_WIDTH-1:0]  ssum1_nxt;
  logic signed [33:0]    nsum1_nxt;

  logic [2:0]            op1_r;
  logic signed [31:0]    an1_r;
  logic [SEC_WIDTH-1:0]  as1_r, ssum1_r;
  logic signed [33:0]    nsum1_r;

  assign a_s    = in_data.a_sec;
  assign b_s    = in_data.b_sec;
  assign an_s   = in_data.a_nsec;
  assign bn_s   = in_data.b_nsec;
  assign as_ext = SEC_WIDTH'(a_s);
  assign bs_ext = SEC_WIDTH'(b_s);
  assign an_in  = 34'(an_s);
  assign bn_in  = 34'(bn_s);

  assign ssum1_nxt = (in_data.operation == OP_SUB) ? as_ext - bs_ext : as_ext + bs_ext;
  assign nsum1_nxt = (in_data.operation == OP_SUB) ? an_in - bn_in : an_in + bn_in;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      op1_r   <= in_data.operation;
      an1_r   <= an_s;
      as1_r   <= as_ext;
      ssum1_r <= ssum1_nxt;
      nsum1_r <= nsum1_nxt;
    end
  end

  // ---------------- stage 2: carry/borrow fix-up, normalize fold ----------------
  logic signed [33:0]    an1_x;
  logic [SEC_WIDTH-1:0]  sec2_nxt, sec2_r;
  logic signed [33:0]    ns2_nxt, ns2_r;
  logic                  sat2_nxt, sat2_r;    // negative seconds saturate (else zero)
  logic                  zero2_nxt, zero2_r;  // negative input to normalize
  logic                  time2_nxt, time2_r;  // op belongs to this path

  assign an1_x = 34'(an1_r);

  always_comb begin
    sec2_nxt  = ssum1_r;
    ns2_nxt   = nsum1_r;
    sat2_nxt  = 1'b0;
    zero2_nxt = 1'b0;
    time2_nxt = 1'b1;
    case (op1_r)
      OP_ADD: begin
        sat2_nxt = 1'b1;
        if (nsum1_r >= NS1_34) begin
          sec2_nxt = ssum1_r + SEC_ONE;
          ns2_nxt  = nsum1_r - NS1_34;
        end
      end
      OP_SUB: begin
        if (nsum1_r[33]) begin
          sec2_nxt = ssum1_r - SEC_ONE;
          ns2_nxt  = nsum1_r + NS1_34;
        end
      end
      OP_NORM: begin
        sec2_nxt = as1_r;
        ns2_nxt  = an1_x;
        if (as1_r[SEC_WIDTH-1] || (as1_r == '0 && an1_r[31])) begin
          zero2_nxt = 1'b1;
        end else if (!an1_r[31]) begin
          // fold whole seconds out of the nanoseconds
          sat2_nxt = 1'b1;
          if (an1_x >= NS2_34) begin
            sec2_nxt = as1_r + SEC_TWO;
            ns2_nxt  = an1_x - NS2_34;
          end else if (an1_x >= NS1_34) begin
            sec2_nxt = as1_r + SEC_ONE;
            ns2_nxt  = an1_x - NS1_34;
          end
        end else begin
          // borrow enough seconds to make the nanoseconds non-negative
          if (an1_x >= -NS1_34) begin
            sec2_nxt = as1_r - SEC_ONE;
            ns2_nxt  = an1_x + NS1_34;
          end else if (an1_x >= -NS2_34) begin
            sec2_nxt = as1_r - SEC_TWO;
            ns2_nxt  = an1_x + NS2_34;
          end else begin
            sec2_nxt = as1_r - SEC_THR;
            ns2_nxt  = an1_x + NS3_34;
          end
        end
      end
      default: begin
        time2_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      sec2_r  <= sec2_nxt;
      ns2_r   <= ns2_nxt;
      sat2_r  <= sat2_nxt;
      zero2_r <= zero2_nxt;
      time2_r <= time2_nxt;
    end
  end

  // ---------------- stage 3: clamp or saturate ----------------
  out_t res3_nxt, res3_r, res4_r, res5_r;

  always_comb begin
    res3_nxt = '0;
    if (time2_r) begin
      if (zero2_r || (sec2_r[SEC_WIDTH-1] && !sat2_r)) begin
        res3_nxt.clamp_status = ST_ZERO;
      end else if (sec2_r[SEC_WIDTH-1]) begin
        res3_nxt.res_sec      = SEC_MAX[31:0];
        res3_nxt.res_nsec     = NS_MAX;
        res3_nxt.clamp_status = ST_SAT;
      end else begin
        res3_nxt.res_sec      = sec2_r[31:0];
        res3_nxt.res_nsec     = ns2_r[31:0];
        res3_nxt.clamp_status = ST_NONE;
      end
    end
  end

  // Stages 3..5: result rides along to the output register
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      res3_r <= res3_nxt;
    end
    if (ctl.load[3]) begin
      res4_r <= res3_r;
    end
    if (ctl.load[4]) begin
      res5_r <= res4_r;
    end
  end

  assign res = res5_r;

endmodule

`default_nettype wire

>>> src/snt_conv_path.sv
// Count-to-time conversion (ms, us) by reciprocal multiply plus one correction,
// and time-to-nanoseconds by multiply-add. Depends on snt_pkg.
`default_nettype none

module snt_conv_path (
  input  wire logic                clk,
  input  wire snt_pkg::pipe_ctl_t  ctl,
  input  wire snt_pkg::in_t        in_data,
  output snt_pkg::out_t            res
);
  import snt_pkg::*;

  // ---------------- stage 1: capture ----------------
  logic [2:0]          op1_r;
  logic [30:0]         cnt1_r;
  logic signed [31:0]  as1_r, an1_r;

  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      op1_r  <= in_data.operation;
      cnt1_r <= in_data.count_in;
      as1_r  <= in_data.a_sec;
      an1_r  <= in_data.a_nsec;
    end
  end

  // ---------------- stage 2: reciprocal multiply, seconds * 1e9 ----------------
  logic [31:0]         recip;
  logic [PROD_W-1:0]   prod2_nxt, prod2_r;
  logic signed [61:0]  mul2_nxt, mul2_r;
  logic [2:0]          op2_r;
  logic [30:0]         cnt2_r;
  logic signed [31:0]  an2_r;

  assign recip     = (op1_r == OP_FROM_US) ? RECIP_US : RECIP_MS;
  assign prod2_nxt = PROD_W'(cnt1_r) * PROD_W'(recip);
  assign mul2_nxt  = 62'(as1_r) * 62'(NS_PER_SEC_32);

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      prod2_r <= prod2_nxt;
      mul2_r  <= mul2_nxt;
      op2_r   <= op1_r;
      cnt2_r  <= cnt1_r;
      an2_r   <= an1_r;
    end
  end

  // ---------------- stage 3: quotient estimate times divisor; total ----------------
  logic [QUO_W-1:0]        qe3_nxt, qe3_r;
  logic [DIV_W-1:0]        div2;
  logic [QUO_W+DIV_W-1:0]  qd_full;
  logic [30:0]             qd3_r;
  logic signed [63:0]      total3_nxt, total3_r;
  logic [2:0]              op3_r;
  logic [30:0]             cnt3_r;

  assign qe3_nxt    = (op2_r == OP_FROM_US) ? QUO_W'(prod2_r[PROD_W-1:SHIFT_US])
                                            : QUO_W'(prod2_r[PROD_W-1:SHIFT_MS]);
  assign div2       = (op2_r == OP_FROM_US) ? DIV_US : DIV_MS;
  assign qd_full    = {{DIV_W{1'b0}}, qe3_nxt} * {{QUO_W{1'b0}}, div2};
  assign total3_nxt = 64'(mul2_r) + 64'(an2_r);

  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      qe3_r    <= qe3_nxt;
      qd3_r    <= qd_full[30:0];
      total3_r <= total3_nxt;
      op3_r    <= op2_r;
      cnt3_r   <= cnt2_r;
    end
  end

  // ---------------- stage 4: remainder and one correction step ----------------
  logic [30:0]         diff3;
  logic [DIV_W:0]      rem_raw;
  logic [DIV_W-1:0]    div3;
  logic [QUO_W-1:0]    q4_nxt, q4_r;
  logic [REM_W-1:0]    r4_nxt, r4_r;
  logic signed [63:0]  total4_r;
  logic [2:0]          op4_r;

  assign diff3   = cnt3_r - qd3_r;
  assign rem_raw = diff3[DIV_W:0];  // below twice the divisor
  assign div3    = (op3_r == OP_FROM_US) ? DIV_US : DIV_MS;

  always_comb begin
    q4_nxt = qe3_r;
    r4_nxt = rem_raw[REM_W-1:0];
    if (rem_raw >= {1'b0, div3}) begin
      q4_nxt = qe3_r + QUO_W'(1);
      r4_nxt = REM_W'(rem_raw - {1'b0, div3});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[3]) begin
      q4_r     <= q4_nxt;
      r4_r     <= r4_nxt;
      total4_r <= total3_r;
      op4_r    <= op3_r;
    end
  end

  // ---------------- stage 5: scale remainder to nanoseconds, select ----------------
  logic [DIV_W-1:0]        scale4;
  logic [REM_W+DIV_W-1:0]  ns_full;
  out_t                    res5_nxt, res5_r;

  assign scale4  = (op4_r == OP_FROM_US) ? SCALE_US : SCALE_MS;
  assign ns_full = {{DIV_W{1'b0}}, r4_r} * {{REM_W{1'b0}}, scale4};

  always_comb begin
    res5_nxt = '0;
    case (op4_r)
      OP_FROM_MS, OP_FROM_US: begin
        res5_nxt.res_sec  = 32'(q4_r);
        res5_nxt.res_nsec = ns_full[31:0];
      end
      OP_TO_NS: begin
        res5_nxt.total_ns = total4_r;
      end
      default: begin
        res5_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load[4]) begin
      res5_r <= res5_nxt;
    end
  end

  assign res = res5_r;

endmodule

`default_nettype wire

>>> src/sec_nsec_time_arithmetic.sv
// Second/nanosecond time arithmetic unit: pipeline control and the two datapaths.
// Depends on snt_pkg, snt_pipe_ctrl, snt_time_path and snt_conv_path.
//
// Usage:
//   Input channel in_valid/in_stall/in_data carries one operation per transfer:
//   add, subtract, normalize, milliseconds or microseconds to time, or time to
//   nanoseconds. Output channel out_valid/out_stall/out_data returns exactly one
//   result per input, in order, with a clamp status (zero or infinity).
//   The five register stages (sums or capture, fix-up or reciprocal multiply,
//   clamp or quotient times divisor, remainder correction, output register) lie
//   between input transfer and out_valid. Throughput is one item per cycle
//   while the receiver does not stall; every stage has its own valid bit.
//   When the receiver stalls, the output register holds its result and the
//   stages behind it keep filling empty slots; in_stall rises only once all
//   five stages hold data. Synchronous reset (rst_n low) empties the pipeline;
//   no state survives between items. SEC_WIDTH sets the width of the internal
//   seconds arithmetic (32 to 64); results report its low 32 bits.
`default_nettype none

module sec_nsec_time_arithmetic #(
  parameter int SEC_WIDTH = snt_pkg::SEC_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire snt_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output snt_pkg::out_t      out_data
);
  import snt_pkg::*;

  pipe_ctl_t ctl;
  out_t      time_res, conv_res;

  snt_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  snt_time_path #(
    .SEC_WIDTH (SEC_WIDTH)
  ) u_time (
    .clk     (clk),
    .ctl     (ctl),
    .in_data (in_data),
    .res     (time_res)
  );

  snt_conv_path u_conv (
    .clk     (clk),
    .ctl     (ctl),
    .in_data (in_data),
    .res     (conv_res)
  );

  // Each path zeroes the results of operations it does not own
  assign out_data = out_t'(time_res | conv_res);

  // Input only stalls when the whole pipeline is backed up behind the output
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall)
  ) else $error("input stalled while pipeline has room");

  // Saturation always reports the infinity nanoseconds
  a_sat_value: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clamp_status == ST_SAT) |-> (out_data.res_nsec == NS_MAX)
  ) else $error("saturated result with wrong nanoseconds");

  // Clamp to zero always reports the zero time value
  a_zero_value: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clamp_status == ST_ZERO) |->
      (out_data.res_sec == '0 && out_data.res_nsec == '0 && out_data.total_ns == '0)
  ) else $error("zero-clamped result not zero");

endmodule

`default_nettype wire

>>> bench/snt_checker.sv
`timescale 1ns / 1ps
// Result checker for sec_nsec_time_arithmetic. It watches both channels, predicts each
// result from the accepted input and compares it field by field. Depends on snt_pkg.
module snt_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  snt_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_stall,
  input  snt_pkg::out_t out_data,
  output int            fail_count,
  output int            pending
);
  import snt_pkg::*;

  localparam longint      ONE_SEC_NS = 64'sd1000000000;
  localparam logic [31:0] SEC_INF    = 32'h7FFF_FFFF;

  // results still owed by the unit, oldest first
  out_t expected_q[$];
  out_t want;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // expected result of one input transfer; seconds wrap at 32 bits
  function automatic out_t predict_result(in_t d);
    out_t        r;
    logic [31:0] sec;
    longint      an, bn, ns, q, k, s, cnt;
    r   = '0;
    sec = '0;
    ns  = 0;
    an  = longint'($signed(d.a_nsec));
    bn  = longint'($signed(d.b_nsec));
    cnt = longint'(d.count_in);
    case (d.operation)
      OP_ADD: begin
        sec = d.a_sec + d.b_sec;
        ns  = an + bn;
        // single carry step only
        if (ns >= ONE_SEC_NS) begin
          sec = sec + 32'd1;
          ns  = ns - ONE_SEC_NS;
        end
        if (sec[31]) begin
          sec            = SEC_INF;
          ns             = ONE_SEC_NS - 1;
          r.clamp_status = ST_SAT;
        end
      end
      OP_SUB: begin
        sec = d.a_sec - d.b_sec;
        ns  = an - bn;
        // single borrow step only
        if (ns < 0) begin
          sec = sec - 32'd1;
          ns  = ns + ONE_SEC_NS;
        end
        if (sec[31]) begin
          sec            = '0;
          ns             = 0;
          r.clamp_status = ST_ZERO;
        end
      end
      OP_NORM: begin
        if (d.a_sec[31] || (d.a_sec == 32'd0 && an < 0)) begin
          r.clamp_status = ST_ZERO;
        end else if (an >= 0) begin
          q   = an / ONE_SEC_NS;
          sec = d.a_sec + q[31:0];
          ns  = an - q * ONE_SEC_NS;
          if (sec[31]) begin
            sec            = SEC_INF;
            ns             = ONE_SEC_NS - 1;
            r.clamp_status = ST_SAT;
          end
        end else begin
          // borrow whole seconds until the nanoseconds are non-negative
          k = (ONE_SEC_NS - 1 - an) / ONE_SEC_NS;
          s = longint'($signed(d.a_sec)) - k;
          if (s < 0) begin
            r.clamp_status = ST_ZERO;
          end else begin
            sec = s[31:0];
            ns  = an + k * ONE_SEC_NS;
          end
        end
      end
      OP_FROM_MS: begin
        sec = 32'(cnt / 1000);
        ns  = (cnt % 1000) * 1000000;
      end
      OP_FROM_US: begin
        sec = 32'(cnt / 1000000);
        ns  = (cnt % 1000000) * 1000;
      end
      OP_TO_NS: r.total_ns = longint'($signed(d.a_sec)) * ONE_SEC_NS + an;
      default: ;
    endcase
    r.res_sec  = sec;
    r.res_nsec = ns[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // compare result transfers, then queue the prediction for an input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result transfer with no input outstanding");
        end else begin
          want = expected_q.pop_front();
          if (out_data.res_sec !== want.res_sec)
            report_mismatch($sformatf("res_sec got %0d expected %0d",
                                      $signed(out_data.res_sec), $signed(want.res_sec)));
          if (out_data.res_nsec !== want.res_nsec)
            report_mismatch($sformatf("res_nsec got %0d expected %0d",
                                      $signed(out_data.res_nsec), $signed(want.res_nsec)));
          if (out_data.total_ns !== want.total_ns)
            report_mismatch($sformatf("total_ns got %0d expected %0d",
                                      $signed(out_data.total_ns), $signed(want.total_ns)));
          if (out_data.clamp_status !== want.clamp_status)
            report_mismatch($sformatf("clamp_status got %0d expected %0d",
                                      out_data.clamp_status, want.clamp_status));
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(predict_result(in_data));
    end
    pending <= expected_q.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Top-level testbench for sec_nsec_time_arithmetic: clock, reset, stimulus and verdict.
// Depends on snt_pkg, the unit itself and snt_checker.
module tb;
  import snt_pkg::*;

  localparam int                 WATCHDOG_LIMIT = 2000;
  localparam int                 RANDOM_ITEMS   = 500;
  localparam logic [2:0]         OP_RSVD6       = 3'd6;
  localparam logic [2:0]         OP_RSVD7       = 3'd7;
  localparam logic signed [31:0] S32_MAX        = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN        = 32'sh8000_0000;
  localparam logic signed [31:0] NS_TOP         = 32'sd999999999;
  localparam logic signed [31:0] NS_ONE_SEC     = 32'sd1000000000;
  localparam logic [30:0]        CNT_MAX        = '1;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  out_t out_data;

  logic in_taken     = 1'b0;
  bit   idle_en      = 1'b0;
  int   stall_left   = 0;
  int   quiet_cycles = 0;
  int   fail_count;
  int   pending;

  always #2 clk = ~clk;

  sec_nsec_time_arithmetic u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  snt_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // input transfer flag, read by the driver at the following falling edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
  end

  // receiver stalls in random bursts while idling is enabled
  always @(negedge clk) begin
    if (!idle_en) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // entered and left at a falling edge; optional sender gap before the item
  task automatic push_item(input in_t item);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(negedge clk); while (!in_taken);
  endtask

  function automatic in_t make_item(logic [2:0] op, logic signed [31:0] as,
                                    logic signed [31:0] an, logic signed [31:0] bs,
                                    logic signed [31:0] bn, logic [30:0] cnt);
    in_t d;
    d.operation = op;
    d.a_sec     = as;
    d.a_nsec    = an;
    d.b_sec     = bs;
    d.b_nsec    = bn;
    d.count_in  = cnt;
    return d;
  endfunction

  function automatic logic signed [31:0] rand_sec();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1000);
      2:       return S32_MAX - $urandom_range(0, 3);
      3:       return -$signed({1'b0, 31'($urandom_range(0, 1000))});
      default: return $urandom_range(0, S32_MAX);
    endcase
  endfunction

  // mostly well-formed nanoseconds, with boundaries and raw values mixed in
  function automatic logic signed [31:0] rand_nsec();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return $urandom_range(NS_TOP - 10, NS_ONE_SEC + 10);
      2:       return -$signed({1'b0, 31'($urandom_range(0, NS_TOP))});
      3:       return $urandom_range(NS_ONE_SEC, S32_MAX);
      4:       return S32_MIN + $urandom_range(0, 3);
      default: return $urandom_range(0, NS_TOP);
    endcase
  endfunction

  function automatic logic [30:0] rand_count();
    case ($urandom_range(0, 3))
      0:       return 31'($urandom_range(0, 5000));
      1:       return 31'(CNT_MAX - $urandom_range(0, 1000));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic in_t rand_item();
    logic [2:0] op;
    if ($urandom_range(0, 19) == 0) op = 3'($urandom_range(OP_RSVD6, OP_RSVD7));
    else op = 3'($urandom_range(OP_ADD, OP_TO_NS));
    return make_item(op, rand_sec(), rand_nsec(), rand_sec(), rand_nsec(), rand_count());
  endfunction

  initial begin
    int i;
    repeat (2) @(negedge clk);
    rst_n   <= 1'b1;
    idle_en <= 1'b1;

    // add: plain, carry, overflow by carry and by wrap, negative operand, unnormalized
    push_item(make_item(OP_ADD, 1, 500000000, 2, 400000000, 0));
    push_item(make_item(OP_ADD, 1, 600000000, 2, 700000000, 0));
    push_item(make_item(OP_ADD, S32_MAX, NS_TOP, 0, 1, 0));
    push_item(make_item(OP_ADD, S32_MAX, 0, 1, 0, 0));
    push_item(make_item(OP_ADD, -5, 0, 2, 0, 0));
    push_item(make_item(OP_ADD, 0, S32_MAX, 0, S32_MAX, 0));
    push_item(make_item(OP_ADD, 0, S32_MIN, 0, S32_MIN, 0));
    // subtract: plain, borrow, underflow, underflow by borrow, unnormalized, seconds wrap
    push_item(make_item(OP_SUB, 5, 700000000, 2, 200000000, 0));
    push_item(make_item(OP_SUB, 5, 100000000, 2, 200000000, 0));
    push_item(make_item(OP_SUB, 2, 0, 3, 0, 0));
    push_item(make_item(OP_SUB, 0, 0, 0, 1, 0));
    push_item(make_item(OP_SUB, 0, S32_MIN, 0, S32_MAX, 0));
    push_item(make_item(OP_SUB, S32_MIN, 0, S32_MAX, 0, 0));
    // normalize: negative, zero with negative ns, big fold, overflow, borrow, underflow
    push_item(make_item(OP_NORM, -1, 5, 0, 0, 0));
    push_item(make_item(OP_NORM, 0, -1, 0, 0, 0));
    push_item(make_item(OP_NORM, 3, S32_MAX, 0, 0, 0));
    push_item(make_item(OP_NORM, S32_MAX, NS_ONE_SEC, 0, 0, 0));
    push_item(make_item(OP_NORM, 5, -1, 0, 0, 0));
    push_item(make_item(OP_NORM, 1, S32_MIN, 0, 0, 0));
    // conversions at the count extremes
    push_item(make_item(OP_FROM_MS, 0, 0, 0, 0, 0));
    push_item(make_item(OP_FROM_MS, 0, 0, 0, 0, CNT_MAX));
    push_item(make_item(OP_FROM_US, 0, 0, 0, 0, CNT_MAX));
    push_item(make_item(OP_TO_NS, S32_MAX, S32_MAX, 0, 0, 0));
    push_item(make_item(OP_TO_NS, S32_MIN, S32_MIN, 0, 0, 0));
    // unused operation codes
    push_item(make_item(OP_RSVD6, -1, -1, -1, -1, CNT_MAX));
    push_item(make_item(OP_RSVD7, -1, -1, -1, -1, CNT_MAX));

    // random items; idling off in a middle stretch and at the end
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      idle_en <= (i < 150) || (i >= 250 && i < 420);
      push_item(rand_item());
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (2 * NSTAGE) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> sec_nsec_time_arithmetic.f
src/snt_pkg.sv
src/snt_pipe_ctrl.sv
src/snt_time_path.sv
src/snt_conv_path.sv
src/sec_nsec_time_arithmetic.sv
bench/snt_checker.sv
bench/tb.sv
